/* hw/rtl/ffbm_pkg.sv */
`timescale 1ns / 1ps
// Package for the FFT band-limit mask generator: field widths, register indexes,
// fixed-point constants and the elaboration-time square-root and power table functions.
// Depends on nothing.
package ffbm_pkg;

    localparam int unsigned IDX_W      = 12;
    localparam int unsigned DIM_W      = 13;
    localparam int unsigned STEP_W     = 25;
    localparam int unsigned IPC_W      = 41;
    localparam int unsigned MASK_W     = 41;
    localparam int unsigned IN_TDATA_W = 24;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 41;
    localparam int unsigned MAX_DIM_DEF = 4096;

    localparam int unsigned MAG_W  = 13;
    localparam int unsigned SF_W   = 38;
    localparam int unsigned K_W    = 26;
    localparam int unsigned SQR_W  = 52;
    localparam int unsigned R2_W   = 53;
    localparam int unsigned RT_W   = 54;
    localparam int unsigned SQ_N   = 27;
    localparam int unsigned POW_N  = 30;
    localparam int unsigned DIV_N  = 31;

    localparam logic [K_W-1:0]  K_MAX         = '1;
    localparam logic [26:0]     MU_Q24        = 27'd10345950;
    localparam logic [22:0]     LOG2E_OVER_T  = 23'd6303231;
    localparam logic [30:0]     ONE_Q30       = 31'd1 << 30;
    localparam logic [42:0]     ONE_Q40       = 43'd1 << 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_GRID_WIDTH  = 3'd1,
        CFG_GRID_HEIGHT = 3'd2,
        CFG_X_STEP      = 3'd3,
        CFG_Y_STEP      = 3'd4,
        CFG_INV_PIXELS  = 3'd5
    } t_cfg_idx;

    localparam logic MODE_SHARP  = 1'b0;
    localparam logic MODE_SMOOTH = 1'b1;

    function automatic logic [MAG_W-1:0] f_fold(input logic [IDX_W-1:0] idx,
                                                input logic [DIM_W-1:0] dim);
        logic [MAG_W-1:0] ext;
        logic [MAG_W-1:0] mag;
        ext = MAG_W'(idx);
        mag = ext;
        if (ext > (dim >> 1)) begin
            mag = (ext >= dim) ? (ext - dim) : (dim - ext);
        end
        return mag;
    endfunction

    function automatic logic [63:0] f_isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        for (int i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // Factor 2^(-2^-k) in Q0.30, built as a chain of square roots from one half.
    function automatic logic [29:0] f_pow_tab(input int k);
        logic [63:0] p;
        p = f_isqrt64(64'd1 << 59);
        for (int j = 2; j <= POW_N; j++) begin
            if (j <= k) begin
                p = f_isqrt64(p << 30);
            end
        end
        return p[29:0];
    endfunction

endpackage

/* hw/rtl/fft_bandlimit_mask_generator_unit.sv */
`timescale 1ns / 1ps
// FFT band-limit mask generator: a radial low-pass weight for each frequency bin.
// Depends on ffbm_pkg.
//
// Usage: the slave stream takes one item per bin, the column index in tdata[11:0]
// and the row index in tdata[23:12]. The master stream returns the mask weight,
// unsigned Q1.40, in tdata[40:0]. Registers are written over the cfg channel,
// which is always ready; they should only change while no item is in flight.
// Throughput is one item per cycle unless the output stalls. From acceptance to
// the valid result, five stages fold, scale and square the frequencies,
// 27 stages take the square root one result bit each, three form the exponent,
// 30 stages each apply one power-table multiply, two prepare the quotient,
// 31 stages divide one quotient bit each and three scale and saturate.
// The pipeline advances as a whole; when the output holds an item that the
// receiver does not take, every stage holds and s_axis_tready is low.
// Reset clears all valid bits and loads the register defaults: sharp mode,
// a 256 by 256 grid, steps of 1/128 Nyquist and a scale of 2^-16.
module fft_bandlimit_mask_generator_unit #(
    parameter int unsigned MAX_DIM = ffbm_pkg::MAX_DIM_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ffbm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ffbm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: col_index[11:0], row_index[23:12].
    input  logic [ffbm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: mask_value[40:0], zero fill[47:41].
    output logic [ffbm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import ffbm_pkg::*;

    localparam int unsigned LP_STAGES = 5 + SQ_N + 3 + POW_N + 2 + DIV_N + 3;
    localparam logic [DIM_W-1:0] LP_DIM_CAP =
        (MAX_DIM > (2 ** DIM_W - 1)) ? DIM_W'(2 ** DIM_W - 1) : DIM_W'(MAX_DIM);
    localparam logic signed [23:0] LP_W_MUL = $signed({1'b0, LOG2E_OVER_T});

    typedef struct packed {
        logic [RT_W-1:0] v;
        logic [RT_W-1:0] res;
        logic            over;
    } t_sqrt_stg;

    typedef struct packed {
        logic [30:0] p;
        logic [29:0] fr;
        logic [4:0]  sh;
        logic        pzero;
        logic        neg;
        logic        over;
    } t_pow_stg;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] den;
        logic [30:0] nlo;
        logic [30:0] q;
        logic        over;
    } t_div_stg;

    logic                r_mode;
    logic [DIM_W-1:0]    r_grid_width;
    logic [DIM_W-1:0]    r_grid_height;
    logic [STEP_W-1:0]   r_x_step;
    logic [STEP_W-1:0]   r_y_step;
    logic [IPC_W-1:0]    r_inv_pixels;

    logic [LP_STAGES-1:0] r_vld;
    logic                 w_adv;

    logic [DIM_W-1:0]    w_dim_x;
    logic [DIM_W-1:0]    w_dim_y;
    logic [MAG_W-1:0]    r_mag_x;
    logic [MAG_W-1:0]    r_mag_y;
    logic [SF_W-1:0]     r_sf_x;
    logic [SF_W-1:0]     r_sf_y;
    logic [K_W-1:0]      r_k_x;
    logic [K_W-1:0]      r_k_y;
    logic [SQR_W-1:0]    r_sqr_x;
    logic [SQR_W-1:0]    r_sqr_y;
    logic [R2_W-1:0]     r_r2;

    t_sqrt_stg           w_sq_in [SQ_N];
    t_sqrt_stg           n_sq    [SQ_N];
    t_sqrt_stg           r_sq    [SQ_N];

    logic signed [27:0]  r_d;
    logic                r_d_over;
    logic signed [51:0]  r_w;
    logic                r_w_over;
    logic [51:0]         w_abs;

    t_pow_stg            n_pw_head;
    t_pow_stg            w_pw_in [POW_N + 1];
    t_pow_stg            n_pw    [POW_N];
    t_pow_stg            r_pw    [POW_N + 1];

    logic [30:0]         r_p;
    logic                r_p_neg;
    logic                r_p_over;

    t_div_stg            n_dv_head;
    t_div_stg            w_dv_in [DIV_N + 1];
    t_div_stg            n_dv    [DIV_N];
    t_div_stg            r_dv    [DIV_N + 1];

    logic [51:0]         r_prod_hi;
    logic [50:0]         r_prod_lo;
    logic                r_prod_over;
    logic [42:0]         r_m;
    logic                r_m_over;
    logic [42:0]         w_sel;
    logic [MASK_W-1:0]   r_out;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_SHARP;
            r_grid_width  <= DIM_W'(256);
            r_grid_height <= DIM_W'(256);
            r_x_step      <= STEP_W'(131072);
            r_y_step      <= STEP_W'(131072);
            r_inv_pixels  <= IPC_W'(16777216);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MODE:        r_mode        <= i_cfg_data[0];
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[DIM_W-1:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[DIM_W-1:0];
                CFG_X_STEP:      r_x_step      <= i_cfg_data[STEP_W-1:0];
                CFG_Y_STEP:      r_y_step      <= i_cfg_data[STEP_W-1:0];
                CFG_INV_PIXELS:  r_inv_pixels  <= i_cfg_data[IPC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline control.
    assign w_adv         = !r_vld[LP_STAGES-1] || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LP_STAGES-2:0], s_axis_tvalid};
        end
    end

    // Fold, scale, clamp, square and sum.
    assign w_dim_x = (r_grid_width > LP_DIM_CAP) ? LP_DIM_CAP : r_grid_width;
    assign w_dim_y = (r_grid_height > LP_DIM_CAP) ? LP_DIM_CAP : r_grid_height;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mag_x <= f_fold(s_axis_tdata[IDX_W-1:0], w_dim_x);
            r_mag_y <= f_fold(s_axis_tdata[2*IDX_W-1:IDX_W], w_dim_y);
            r_sf_x  <= SF_W'(r_mag_x) * SF_W'(r_x_step);
            r_sf_y  <= SF_W'(r_mag_y) * SF_W'(r_y_step);
            r_k_x   <= (r_sf_x > SF_W'(K_MAX)) ? K_MAX : r_sf_x[K_W-1:0];
            r_k_y   <= (r_sf_y > SF_W'(K_MAX)) ? K_MAX : r_sf_y[K_W-1:0];
            r_sqr_x <= SQR_W'(r_k_x) * SQR_W'(r_k_x);
            r_sqr_y <= SQR_W'(r_k_y) * SQR_W'(r_k_y);
            r_r2    <= R2_W'(r_sqr_x) + R2_W'(r_sqr_y);
        end
    end

    // Square root, one result bit per stage. The sharp cutoff test rides along.
    always_comb begin
        w_sq_in[0].v    = RT_W'(r_r2);
        w_sq_in[0].res  = '0;
        w_sq_in[0].over = (({4'b0, r_r2} << 3) + 57'(r_r2)) > (57'd1 << 50);
    end

    for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
        localparam logic [RT_W-1:0] LP_B = RT_W'(1) << (2 * (SQ_N - 1 - g));
        logic [RT_W-1:0] w_trial;

        if (g > 0) begin : g_link
            assign w_sq_in[g] = r_sq[g-1];
        end

        assign w_trial = w_sq_in[g].res + LP_B;

        always_comb begin
            n_sq[g].over = w_sq_in[g].over;
            if (w_sq_in[g].v >= w_trial) begin
                n_sq[g].v   = w_sq_in[g].v - w_trial;
                n_sq[g].res = (w_sq_in[g].res >> 1) + LP_B;
            end else begin
                n_sq[g].v   = w_sq_in[g].v;
                n_sq[g].res = w_sq_in[g].res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq[g] <= n_sq[g];
            end
        end
    end

    // Exponent w = (r - mu) * log2(e) / T, then split into integer and fraction.
    assign w_abs = r_w[51] ? 52'(-r_w) : 52'(r_w);

    always_comb begin
        n_pw_head.p     = ONE_Q30;
        n_pw_head.fr    = w_abs[39:10];
        n_pw_head.sh    = w_abs[44:40];
        n_pw_head.pzero = w_abs[49:40] > 10'd30;
        n_pw_head.neg   = r_w[51];
        n_pw_head.over  = r_w_over;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d      <= $signed({1'b0, r_sq[SQ_N-1].res[26:0]}) - $signed({1'b0, MU_Q24});
            r_d_over <= r_sq[SQ_N-1].over;
            r_w      <= r_d * LP_W_MUL;
            r_w_over <= r_d_over;
            r_pw[0]  <= n_pw_head;
        end
    end

    // 2^-fraction, one table factor per stage.
    for (genvar g = 0; g < POW_N; g++) begin : g_pow
        localparam logic [29:0] LP_T = f_pow_tab(g + 1);
        logic [60:0] w_prod;

        assign w_pw_in[g] = r_pw[g];

        assign w_prod = 61'(w_pw_in[g].p) * 61'(LP_T);

        always_comb begin
            n_pw[g] = w_pw_in[g];
            if (w_pw_in[g].fr[POW_N-1-g]) begin
                n_pw[g].p = w_prod[60:30];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pw[g+1] <= n_pw[g];
            end
        end
    end

    assign w_pw_in[POW_N] = r_pw[POW_N];

    // Integer shift, then dividend and divisor for the Fermi quotient.
    always_comb begin
        n_dv_head.den  = 32'(ONE_Q30) + 32'(r_p);
        n_dv_head.rem  = r_p_neg ? 32'(ONE_Q30 >> 1) : 32'(r_p[30:1]);
        n_dv_head.nlo  = r_p_neg ? 31'd0 : {r_p[0], 30'd0};
        n_dv_head.q    = '0;
        n_dv_head.over = r_p_over;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p      <= w_pw_in[POW_N].pzero ? 31'd0 : (w_pw_in[POW_N].p >> w_pw_in[POW_N].sh);
            r_p_neg  <= w_pw_in[POW_N].neg;
            r_p_over <= w_pw_in[POW_N].over;
            r_dv[0]  <= n_dv_head;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar g = 0; g < DIV_N; g++) begin : g_div
        logic [31:0] w_part;

        assign w_dv_in[g] = r_dv[g];

        assign w_part = {w_dv_in[g].rem[30:0], w_dv_in[g].nlo[DIV_N-1-g]};

        always_comb begin
            n_dv[g] = w_dv_in[g];
            if (w_part >= w_dv_in[g].den) begin
                n_dv[g].rem = w_part - w_dv_in[g].den;
                n_dv[g].q   = {w_dv_in[g].q[29:0], 1'b1};
            end else begin
                n_dv[g].rem = w_part;
                n_dv[g].q   = {w_dv_in[g].q[29:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[g+1] <= n_dv[g];
            end
        end
    end

    assign w_dv_in[DIV_N] = r_dv[DIV_N];

    // Scale by the pixel-count reciprocal, select the mode and saturate.
    assign w_sel = (r_mode == MODE_SHARP) ? (r_m_over ? 43'd0 : 43'(r_inv_pixels)) : r_m;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod_hi   <= 52'(r_inv_pixels[40:20]) * 52'(w_dv_in[DIV_N].q);
            r_prod_lo   <= 51'(r_inv_pixels[19:0]) * 51'(w_dv_in[DIV_N].q);
            r_prod_over <= w_dv_in[DIV_N].over;
            r_m         <= 43'((53'(r_prod_hi) + 53'(r_prod_lo >> 20)) >> 10);
            r_m_over    <= r_prod_over;
            r_out       <= (w_sel > ONE_Q40) ? ONE_Q40[MASK_W-1:0] : w_sel[MASK_W-1:0];
        end
    end

    assign m_axis_tvalid = r_vld[LP_STAGES-1];
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

    // Checks.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while the output is stalled");

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted item missing from the first stage");

    a_result_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= OUT_TDATA_W'(ONE_Q40)))
        else $error("mask value above one");

    a_sharp_two_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_mode == MODE_SHARP) && (r_inv_pixels <= IPC_W'(ONE_Q40))
        |-> (m_axis_tdata == '0) || (m_axis_tdata == OUT_TDATA_W'(r_inv_pixels)))
        else $error("sharp mode result is neither zero nor the scale");

endmodule

/* dv/tb_fft_bandlimit_mask_generator_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fft_bandlimit_mask_generator_unit: a clocked driver and monitor
// feed grid bins through the streams and compare every mask weight with an in-bench predictor.
// Depends on ffbm_pkg and the mask generator RTL.
module tb_fft_bandlimit_mask_generator_unit;
    import ffbm_pkg::*;

    localparam int unsigned GRID_MAX    = 4096;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam longint      FERMI_MU    = 10345950;
    localparam longint      FERMI_RATE  = 6303231;
    localparam logic [63:0] CLAMP_Q24   = (64'd1 << 26) - 64'd1;
    localparam logic [63:0] UNIT_Q30    = 64'd1 << 30;
    localparam logic [63:0] UNIT_Q40    = 64'd1 << 40;

    typedef struct packed {
        logic        mode;
        logic [12:0] width;
        logic [12:0] height;
        logic [24:0] x_step;
        logic [24:0] y_step;
        logic [40:0] inv_pix;
    } mask_cfg_t;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [40:0] mask;
    } mask_due_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    mask_cfg_t   cfg_copy = '{mode: MODE_SHARP, width: 13'd256, height: 13'd256,
                              x_step: 25'd131072, y_step: 25'd131072, inv_pix: 41'd16777216};
    logic [63:0] pow_fac [1:30];
    logic [23:0] bin_q [$];
    mask_due_t   mask_due_q [$];
    logic        in_taken = 1'b0;
    bit          idle_on = 1'b1;
    int unsigned feed_gap = 0;
    int unsigned stall_left = 0;
    int unsigned n_bins_queued = 0;
    int unsigned n_bins_in = 0;
    int unsigned n_masks_out = 0;
    int unsigned n_sharp_bins = 0;
    int unsigned n_smooth_bins = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned n_settings = 0;
    int unsigned n_errors = 0;
    int unsigned cycle_count = 0;

    fft_bandlimit_mask_generator_unit #(
        .MAX_DIM(GRID_MAX)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] acc;
        logic [63:0] b;
        rem = v;
        acc = '0;
        b   = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= acc + b) begin
                rem = rem - (acc + b);
                acc = (acc >> 1) + b;
            end else begin
                acc = acc >> 1;
            end
            b = b >> 2;
        end
        return acc;
    endfunction

    function automatic logic [25:0] scaled_freq(input logic [11:0] idx, input logic [12:0] dim,
                                                input logic [24:0] step);
        logic [12:0] span;
        logic [12:0] mag;
        logic [37:0] prod;
        span = (dim > GRID_MAX) ? 13'(GRID_MAX) : dim;
        mag  = {1'b0, idx};
        if (mag > (span >> 1)) mag = (mag >= span) ? mag - span : span - mag;
        prod = mag * step;
        return (prod > 38'(CLAMP_Q24)) ? 26'(CLAMP_Q24) : prod[25:0];
    endfunction

    function automatic logic [40:0] predict_mask(input logic [11:0] col, input logic [11:0] row,
                                                 input mask_cfg_t c);
        logic [25:0] kx;
        logic [25:0] ky;
        logic [63:0] r2;
        logic [63:0] mag_w;
        logic [63:0] frac;
        logic [63:0] p;
        logic [63:0] f;
        logic [63:0] m;
        longint      w;
        kx = scaled_freq(col, c.width, c.x_step);
        ky = scaled_freq(row, c.height, c.y_step);
        r2 = 64'(kx) * 64'(kx) + 64'(ky) * 64'(ky);
        if (c.mode == MODE_SHARP) begin
            m = (r2 * 64'd9 > (64'd4 << 48)) ? 64'd0 : 64'(c.inv_pix);
        end else begin
            w     = (longint'(int_sqrt(r2)) - FERMI_MU) * FERMI_RATE;
            mag_w = (w < 0) ? 64'(-w) : 64'(w);
            frac  = (mag_w >> 10) & (UNIT_Q30 - 64'd1);
            p     = UNIT_Q30;
            for (int k = 1; k <= 30; k++) begin
                if (frac[30-k]) p = (p * pow_fac[k]) >> 30;
            end
            p = ((mag_w >> 40) > 64'd30) ? 64'd0 : p >> (mag_w >> 40);
            f = (w >= 0) ? (p << 30) / (UNIT_Q30 + p) : (UNIT_Q30 << 30) / (UNIT_Q30 + p);
            m = (((64'(c.inv_pix) >> 20) * f) + (((64'(c.inv_pix) & 64'hFFFFF) * f) >> 20)) >> 10;
        end
        if (m > UNIT_Q40) m = UNIT_Q40;
        return m[40:0];
    endfunction

    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (!idle_on || roll < 65) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        if (roll < 98) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_taken) begin
            if (feed_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                feed_gap--;
            end else if (bin_q.size() != 0) begin
                s_axis_tdata  <= bin_q.pop_front();
                s_axis_tvalid <= 1'b1;
                feed_gap = idle_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = idle_len();
        end
    end

    always @(posedge i_clk) begin
        mask_due_t due;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_masks_out++;
                if (mask_due_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("Unexpected mask item %0d with no bin pending.",
                                 m_axis_tdata[MASK_W-1:0]);
                end else begin
                    due = mask_due_q.pop_front();
                    if (m_axis_tdata[MASK_W-1:0] !== due.mask) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("Mask mismatch at bin (%0d, %0d): expected %0d, got %0d.",
                                     due.col, due.row, due.mask, m_axis_tdata[MASK_W-1:0]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                due.col  = s_axis_tdata[11:0];
                due.row  = s_axis_tdata[23:12];
                due.mask = predict_mask(due.col, due.row, cfg_copy);
                mask_due_q.push_back(due);
                n_bins_in++;
                if (cfg_copy.mode == MODE_SHARP) n_sharp_bins++;
                else n_smooth_bins++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run timed out with %0d masks outstanding.", mask_due_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_bin(input logic [11:0] col, input logic [11:0] row);
        bin_q.push_back({row, col});
        n_bins_queued++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (n_bins_in != n_bins_queued || mask_due_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [40:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MODE:        cfg_copy.mode    = val[0];
            CFG_GRID_WIDTH:  cfg_copy.width   = val[12:0];
            CFG_GRID_HEIGHT: cfg_copy.height  = val[12:0];
            CFG_X_STEP:      cfg_copy.x_step  = val[24:0];
            CFG_Y_STEP:      cfg_copy.y_step  = val[24:0];
            CFG_INV_PIXELS:  cfg_copy.inv_pix = val;
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [12:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4) return 13'd0;
        if (roll < 8) return 13'h1FFF;
        if (roll < 12) return 13'($urandom_range(8191, GRID_MAX + 1));
        if (roll < 24) return 13'($urandom_range(GRID_MAX, 1));
        return 13'd1 << $urandom_range(12, 1);
    endfunction

    function automatic logic [24:0] pick_step(input int unsigned span);
        logic [24:0] nyq;
        int unsigned roll;
        roll = $urandom_range(99);
        nyq  = 25'((64'd1 << 24) / ((span < 2) ? 1 : span / 2));
        if (roll < 70) return nyq - (nyq >> 4) + 25'($urandom_range(nyq >> 3));
        if (roll < 82) return 25'($urandom);
        if (roll < 90) return 25'd0;
        return '1;
    endfunction

    task automatic run_random_phase(input int unsigned n_bins);
        logic [12:0] w;
        logic [12:0] h;
        logic [40:0] ipc;
        int unsigned span_w;
        int unsigned span_h;
        int unsigned roll;
        w      = pick_dim();
        h      = pick_dim();
        span_w = (w == 0 || w > GRID_MAX) ? GRID_MAX : w;
        span_h = (h == 0 || h > GRID_MAX) ? GRID_MAX : h;
        roll   = $urandom_range(99);
        if (roll < 60) ipc = 41'((64'd1 << 40) / (span_w * span_h));
        else if (roll < 80) ipc = 41'({$urandom, $urandom});
        else if (roll < 90) ipc = 41'(UNIT_Q40);
        else ipc = '1;
        write_reg(CFG_MODE, 41'($urandom_range(1)));
        write_reg(CFG_GRID_WIDTH, 41'(w));
        write_reg(CFG_GRID_HEIGHT, 41'(h));
        write_reg(CFG_X_STEP, 41'(pick_step(span_w)));
        write_reg(CFG_Y_STEP, 41'(pick_step(span_h)));
        write_reg(CFG_INV_PIXELS, ipc);
        n_settings++;
        for (int unsigned i = 0; i < n_bins; i++) begin
            if ($urandom_range(99) < 70)
                queue_bin(12'($urandom_range(span_w - 1)), 12'($urandom_range(span_h - 1)));
            else
                queue_bin(12'($urandom), 12'($urandom));
        end
        wait_drained();
    endtask

    initial begin
        pow_fac[1] = int_sqrt(64'd1 << 59);
        for (int k = 2; k <= 30; k++) pow_fac[k] = int_sqrt(pow_fac[k-1] << 30);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sharp cutoff on the reset grid, probing both sides of the two-thirds radius.
        n_settings++;
        queue_bin(12'd0, 12'd0);
        queue_bin(12'd4095, 12'd4095);
        queue_bin(12'd85, 12'd0);
        queue_bin(12'd0, 12'd86);
        queue_bin(12'd60, 12'd60);
        queue_bin(12'd61, 12'd60);
        queue_bin(12'd128, 12'd129);
        queue_bin(12'd171, 12'd255);
        queue_bin(12'd256, 12'd300);
        wait_drained();

        // Smooth roll-off around the Fermi midpoint.
        write_reg(CFG_MODE, 41'(MODE_SMOOTH));
        n_settings++;
        queue_bin(12'd0, 12'd0);
        queue_bin(12'd78, 12'd0);
        queue_bin(12'd0, 12'd79);
        queue_bin(12'd80, 12'd0);
        queue_bin(12'd100, 12'd0);
        queue_bin(12'd128, 12'd128);
        queue_bin(12'd4095, 12'd0);
        wait_drained();

        // Zero width, oversized height, clamped steps and a saturating scale.
        write_reg(CFG_MODE, 41'(MODE_SHARP));
        write_reg(CFG_GRID_WIDTH, 41'd0);
        write_reg(CFG_GRID_HEIGHT, 41'h1FFF);
        write_reg(CFG_X_STEP, 41'h1FFFFFF);
        write_reg(CFG_Y_STEP, 41'd131072);
        write_reg(CFG_INV_PIXELS, '1);
        n_settings++;
        queue_bin(12'd0, 12'd0);
        queue_bin(12'd1, 12'd2049);
        queue_bin(12'd3, 12'd4095);
        queue_bin(12'd4095, 12'd0);
        wait_drained();
        write_reg(CFG_MODE, 41'(MODE_SMOOTH));
        n_settings++;
        queue_bin(12'd0, 12'd0);
        queue_bin(12'd0, 12'd2100);
        wait_drained();

        for (int unsigned ph = 0; ph < 11; ph++) begin
            idle_on = (ph % 3 != 1);
            run_random_phase(48);
        end
        idle_on = 1'b1;

        repeat (120) @(posedge i_clk);
        $display("Checked %0d masks from %0d bins (%0d sharp, %0d smooth) under %0d settings.",
                 n_masks_out, n_bins_in, n_sharp_bins, n_smooth_bins, n_settings);
        $display("Register writes: %0d, mismatches: %0d.", n_cfg_writes, n_errors);
        if (n_errors == 0 && mask_due_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
